// ===== src/mkh_pkg.sv =====
// ============================================================================
// mkh_pkg: shared types and constants for the Morse key hash table
// Field widths, symbol and status codes, controller states and the
// symbol-to-character mapping used by the running hash.
// ============================================================================
package mkh_pkg;

    // Default table geometry handed to the top level.
    localparam int TABLE_SIZE_DEF  = 173;
    localparam int MAX_KEY_LEN_DEF = 20;

    // Fixed payload widths.
    localparam int SYMBOL_W = 2;
    localparam int LETTER_W = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int CHAR_W   = 6;

    // Symbol codes as they arrive on the key channel.
    typedef enum logic [SYMBOL_W-1:0] {
        SYM_DOT   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_SPACE = 2'd2,
        SYM_NONE  = 2'd3
    } symbol_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    // Character codes folded into the hash.
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 6'd46;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

    // Maps a symbol code to its character code; the empty symbol has none.
    function automatic logic [CHAR_W-1:0] char_of(input symbol_t sym);
        logic [CHAR_W-1:0] c;
        unique case (sym)
            SYM_DOT:   c = CHAR_DOT;
            SYM_DASH:  c = CHAR_DASH;
            SYM_SPACE: c = CHAR_SPACE;
            default:   c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/mkh_if.sv =====
// ============================================================================
// mkh_key_if / mkh_result_if: channels of the Morse key hash table
// Valid/ready channels for incoming key symbols and outgoing probe results.
// ============================================================================
interface mkh_key_if;
    import mkh_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, mode, symbol, last, letter, input ready);
    modport sink   (input valid, mode, symbol, last, letter, output ready);
endinterface

interface mkh_result_if;
    import mkh_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [LETTER_W-1:0] found_letter;

    modport source (output valid, status, slot, found_letter, input ready);
    modport sink   (input valid, status, slot, found_letter, output ready);
endinterface

// ===== src/morse_key_hash_table.sv =====
// ============================================================================
// morse_key_hash_table: open-addressed hash table keyed by Morse strings
// Builds a key one symbol per transaction, then probes a single-port table
// linearly to look up or insert the key together with its letter.
// ============================================================================
// A symbol that does not close a key is only folded into the key builder. For
// the closing symbol the controller steps through S_READ (one synchronous
// memory read) and S_CHECK (compare and optional write-back) once per probed
// slot, then loads the result register in S_OUT; an over-long key skips the
// probe and goes straight to S_OUT. The table is cleared at reset through
// per-slot valid flags, so no clearing pass is needed and the block is ready
// as soon as reset is released. A finished result waits in the output
// register while the next key is already being built; only the next probe's
// end waits for that register to drain.
// ============================================================================
module morse_key_hash_table #(
    parameter int TABLE_SIZE  = mkh_pkg::TABLE_SIZE_DEF,
    parameter int MAX_KEY_LEN = mkh_pkg::MAX_KEY_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mkh_key_if.sink       key,
    mkh_result_if.source  result
);
    import mkh_pkg::*;

    localparam int ADDR_W  = $clog2(TABLE_SIZE);
    localparam int HW      = ADDR_W + 2;
    localparam int LEN_W   = $clog2(MAX_KEY_LEN + 1);
    localparam int CODE_W  = 2 * MAX_KEY_LEN;
    localparam int ENTRY_W = LEN_W + CODE_W + LETTER_W;

    // One hash step: (31 * (h + c)) mod TABLE_SIZE as 32*s - s with doublings.
    function automatic logic [ADDR_W-1:0] hash_step(input logic [ADDR_W-1:0] h,
                                                     input logic [CHAR_W-1:0] c);
        logic [HW-1:0] s;
        logic [HW-1:0] y;
        s = HW'(h) + HW'(c);
        if (s >= HW'(TABLE_SIZE)) s = s - HW'(TABLE_SIZE);
        if (s >= HW'(TABLE_SIZE)) s = s - HW'(TABLE_SIZE);
        y = s;
        for (int i = 0; i < 5; i++) begin
            y = y << 1;
            if (y >= HW'(TABLE_SIZE)) y = y - HW'(TABLE_SIZE);
        end
        if (y >= s) y = y - s;
        else        y = y + HW'(TABLE_SIZE) - s;
        return y[ADDR_W-1:0];
    endfunction

    // Control state.
    state_t              state_reg, state_next;
    logic [CODE_W-1:0]   key_codes_reg, key_codes_next;
    logic [LEN_W-1:0]    key_len_reg, key_len_next;
    logic [ADDR_W-1:0]   hash_reg, hash_next;
    logic                ovf_reg, ovf_next;
    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                out_valid_reg, out_valid_next;

    // Payload state.
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   count_reg, count_next;
    logic                mode_reg, mode_next;
    logic [LETTER_W-1:0] letter_reg, letter_next;
    status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [LETTER_W-1:0] res_letter_reg, res_letter_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [LETTER_W-1:0] out_letter_reg;

    // Table memory.
    logic [ENTRY_W-1:0]  mem [TABLE_SIZE];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [ENTRY_W-1:0]  wr_data;

    // Decoded control.
    logic                in_accept;
    logic                out_load;
    logic                rd_en;
    logic                wr_en;
    logic                room;
    logic [CODE_W-1:0]   codes_upd;
    logic [LEN_W-1:0]    len_upd;
    logic [ADDR_W-1:0]   hash_upd;
    logic                ovf_upd;
    logic [LEN_W-1:0]    rd_len;
    logic [CODE_W-1:0]   rd_codes;
    logic [LETTER_W-1:0] rd_letter;
    logic                hit;
    logic                empty;
    logic                last_probe;

    assign in_accept = key.valid && key.ready;

    // Unpack the entry read from the table and compare it with the key.
    assign rd_len     = rd_data_reg[ENTRY_W-1 -: LEN_W];
    assign rd_codes   = rd_data_reg[LETTER_W +: CODE_W];
    assign rd_letter  = rd_data_reg[LETTER_W-1:0];
    assign empty      = !rd_valid_reg;
    assign hit        = rd_valid_reg && (rd_len == key_len_reg) && (rd_codes == key_codes_reg);
    assign last_probe = (count_reg == ADDR_W'(TABLE_SIZE - 1));
    assign wr_data    = {key_len_reg, key_codes_reg, letter_reg};

    // Key builder with the incoming symbol folded in.
    assign room = (key_len_reg < LEN_W'(MAX_KEY_LEN));

    always_comb
    begin
        codes_upd = key_codes_reg;
        len_upd   = key_len_reg;
        hash_upd  = hash_reg;
        ovf_upd   = ovf_reg;
        if (symbol_t'(key.symbol) != SYM_NONE) begin
            if (room) begin
                codes_upd = key_codes_reg | (CODE_W'(key.symbol) << {key_len_reg, 1'b0});
                len_upd   = key_len_reg + 1'b1;
                hash_upd  = hash_step(hash_reg, char_of(symbol_t'(key.symbol)));
            end else begin
                ovf_upd = 1'b1;
            end
        end
    end

    // Next state of the controller.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && key.last) state_next = ovf_upd ? S_OUT : S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (empty || hit || last_probe) state_next = S_OUT;
                else                            state_next = S_READ;
            end
            S_OUT:
            begin
                if (out_load) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        key.ready = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:  key.ready = 1'b1;
            S_READ:  rd_en     = 1'b1;
            S_CHECK: wr_en     = (empty || hit) && mode_reg;
            S_OUT:   out_load  = !out_valid_reg || result.ready;
            default: key.ready = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        key_codes_next  = key_codes_reg;
        key_len_next    = key_len_reg;
        hash_next       = hash_reg;
        ovf_next        = ovf_reg;
        valid_next      = valid_reg;
        rd_valid_next   = rd_valid_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        letter_next     = letter_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_letter_next = res_letter_reg;

        // Fold in each accepted symbol; the closing one also starts the probe.
        if (in_accept) begin
            key_codes_next = codes_upd;
            key_len_next   = len_upd;
            hash_next      = hash_upd;
            ovf_next       = ovf_upd;
            if (key.last) begin
                mode_next   = key.mode;
                letter_next = key.letter;
                pos_next    = hash_upd;
                count_next  = '0;
                if (ovf_upd) begin
                    res_status_next = ST_LONG;
                    res_slot_next   = '0;
                    res_letter_next = '0;
                end
            end
        end

        // Valid flag travels with the memory read.
        if (rd_en) rd_valid_next = valid_reg[pos_reg];

        // Decide the probe outcome and step to the next slot.
        if (state_reg == S_CHECK) begin
            if (empty || hit) begin
                res_slot_next = SLOT_W'(pos_reg);
                if (mode_reg) begin
                    res_status_next = ST_HIT;
                    res_letter_next = letter_reg;
                end else if (hit) begin
                    res_status_next = ST_HIT;
                    res_letter_next = rd_letter;
                end else begin
                    res_status_next = ST_EMPTY;
                    res_letter_next = '0;
                end
            end else if (last_probe) begin
                res_status_next = ST_FULL;
                res_slot_next   = '0;
                res_letter_next = '0;
            end else begin
                pos_next   = (pos_reg == ADDR_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
        end

        if (wr_en) valid_next[pos_reg] = 1'b1;

        // The key builder starts over once the result is handed on.
        if (out_load) begin
            key_codes_next = '0;
            key_len_next   = '0;
            hash_next      = '0;
            ovf_next       = 1'b0;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)          out_valid_next = 1'b1;
        else if (result.ready) out_valid_next = 1'b0;
        else                   out_valid_next = out_valid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            key_codes_reg <= '0;
            key_len_reg   <= '0;
            hash_reg      <= '0;
            ovf_reg       <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_codes_reg <= key_codes_next;
            key_len_reg   <= key_len_next;
            hash_reg      <= hash_next;
            ovf_reg       <= ovf_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        count_reg      <= count_next;
        mode_reg       <= mode_next;
        letter_reg     <= letter_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_letter_reg <= res_letter_next;
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_letter_reg <= res_letter_reg;
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en) mem[pos_reg] <= wr_data;
        if (rd_en) rd_data_reg <= mem[pos_reg];
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.slot         = out_slot_reg;
    assign result.found_letter = out_letter_reg;

    // A written slot is marked occupied from the next cycle on.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(pos_reg)])
        else $error("written slot not marked occupied");

    // The key builder never holds more symbols than allowed.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_len_reg <= LEN_W'(MAX_KEY_LEN))
        else $error("key length beyond limit");

    // A new result appears only after the controller finished a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside result state");

    // A closing symbol of a key that fits starts a table read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && key.last && !ovf_upd) |=> (state_reg == S_READ))
        else $error("probe not started after closing symbol");

endmodule
